/* hdl/assert_macros.svh */
// assertion helpers used by the cache rtl
// both expect signals named clk and rst in the enclosing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* hdl/dmc_pkg.sv */
package dmc_pkg;

  // geometry
  localparam int CACHE_WORDS = 1024;
  localparam int LINE_WORDS  = 16;
  localparam int ADDR_BITS   = 24;
  localparam int WORD_BITS   = 8;

  localparam int STORE_BITS = $clog2(CACHE_WORDS);
  localparam int OFF_BITS   = $clog2(LINE_WORDS);
  localparam int LINE_BITS  = STORE_BITS - OFF_BITS;
  localparam int NUM_LINES  = CACHE_WORDS / LINE_WORDS;
  localparam int TAG_BITS   = ADDR_BITS - STORE_BITS;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FILL  = 2'd2,
    CMD_INVAL = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_READ    = 3'd0,
    KIND_FILLREQ = 3'd1,
    KIND_UPWRITE = 3'd2,
    KIND_INVDONE = 3'd3,
    KIND_REJECT  = 3'd4
  } kind_t;

  typedef struct packed {
    cmd_t                 command;
    logic [ADDR_BITS-1:0] address;
    logic [WORD_BITS-1:0] data;
  } req_t;

  typedef struct packed {
    kind_t                kind;
    logic                 hit;
    logic [ADDR_BITS-1:0] out_address;
    logic [WORD_BITS-1:0] out_data;
    logic                 last;
  } rsp_t;

  // tag directory control
  typedef struct packed {
    logic                 lookup;
    logic                 install;
    logic                 clear_all;
    logic [LINE_BITS-1:0] index;
    logic [TAG_BITS-1:0]  tag;
  } tag_req_t;

endpackage

/* hdl/direct_mapped_write_through_cache.sv */
// channel    ports                    handshake
// ---------  -----------------------  -----------------------------------------
// request    start, request, busy     word taken at edge with start & !busy
// result     strobe, result           word valid for one cycle while strobe high
//
// fill word, invalidate and rejected commands finish in the cycle they are
// taken; read and write also pass the lookup state (tag and word memory read);
// a write hit then streams the line out of the word memory port in the burst state.
// a result appears the cycle after its command or step finishes and is shown
// while the next command is taken. synchronous reset clears all valid bits and
// the pending fill. the result side cannot stall.
`include "assert_macros.svh"

module direct_mapped_write_through_cache
  import dmc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t request,
  output logic busy,
  output logic strobe,
  output rsp_t result
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LOOKUP = 3'b010,
    S_WBURST = 3'b100
  } state_t;

  state_t                state, state_next;
  req_t                  cur;
  logic                  fill_pending, fill_pending_next;
  logic [ADDR_BITS-1:0]  pending_address;
  logic [OFF_BITS-1:0]   fill_count, fill_count_next;
  logic [WORD_BITS-1:0]  fill_word, fill_word_next;
  logic [OFF_BITS:0]     burst_cnt, burst_cnt_next;
  logic                  strobe_next;
  rsp_t                  result_next;

  logic                  accept;
  logic                  hit;
  tag_req_t              treq;
  logic                  word_en, word_we;
  logic [STORE_BITS-1:0] word_addr;
  logic [WORD_BITS-1:0]  word_wdata, word_rdata;
  logic [OFF_BITS-1:0]   out_idx;

  logic [LINE_BITS-1:0]  in_line, cur_line, pend_line;
  logic [OFF_BITS-1:0]   in_off, cur_off, pend_off;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign in_line   = request.address[STORE_BITS-1:OFF_BITS];
  assign in_off    = request.address[OFF_BITS-1:0];
  assign cur_line  = cur.address[STORE_BITS-1:OFF_BITS];
  assign cur_off   = cur.address[OFF_BITS-1:0];
  assign pend_line = pending_address[STORE_BITS-1:OFF_BITS];
  assign pend_off  = pending_address[OFF_BITS-1:0];
  assign out_idx   = OFF_BITS'(burst_cnt - 1'b1);

  // tag directory and valid bits
  dmc_tag_dir u_tag_dir (
    .clk(clk),
    .rst(rst),
    .req(treq),
    .hit(hit)
  );

  // word memory
  dmc_ram #(
    .DEPTH(CACHE_WORDS),
    .WIDTH(WORD_BITS)
  ) u_word_ram (
    .clk  (clk),
    .en   (word_en),
    .we   (word_we),
    .addr (word_addr),
    .wdata(word_wdata),
    .rdata(word_rdata)
  );

  // command sequencing
  always_comb begin
    state_next        = state;
    fill_pending_next = fill_pending;
    fill_count_next   = fill_count;
    fill_word_next    = fill_word;
    burst_cnt_next    = burst_cnt;
    strobe_next       = 1'b0;
    result_next       = '0;
    result_next.kind  = KIND_REJECT;
    result_next.last  = 1'b1;
    treq              = '0;
    word_en           = 1'b0;
    word_we           = 1'b0;
    word_addr         = {cur_line, cur_off};
    word_wdata        = cur.data;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (request.command)
            CMD_FILL: begin
              if (!fill_pending) begin
                strobe_next = 1'b1;
              end else begin
                // store the fill word, keep the requested one aside
                word_we         = 1'b1;
                word_addr       = {pend_line, fill_count};
                word_wdata      = request.data;
                fill_count_next = fill_count + 1'b1;
                if (fill_count == pend_off) begin
                  fill_word_next = request.data;
                end
                if (&fill_count) begin
                  treq.install            = 1'b1;
                  treq.index              = pend_line;
                  treq.tag                = pending_address[ADDR_BITS-1:STORE_BITS];
                  fill_pending_next       = 1'b0;
                  strobe_next             = 1'b1;
                  result_next.kind        = KIND_READ;
                  result_next.out_address = pending_address;
                  result_next.out_data    = (fill_count == pend_off) ? request.data
                                                                     : fill_word;
                end
              end
            end
            CMD_INVAL: begin
              strobe_next = 1'b1;
              if (!fill_pending) begin
                treq.clear_all   = 1'b1;
                result_next.kind = KIND_INVDONE;
              end
            end
            default: begin
              if (fill_pending) begin
                strobe_next = 1'b1;
              end else begin
                treq.lookup = 1'b1;
                treq.index  = in_line;
                treq.tag    = request.address[ADDR_BITS-1:STORE_BITS];
                word_en     = 1'b1;
                word_addr   = {in_line, in_off};
                state_next  = S_LOOKUP;
              end
            end
          endcase
        end
      end
      S_LOOKUP: begin
        if (cur.command == CMD_READ) begin
          strobe_next = 1'b1;
          if (hit) begin
            result_next.kind        = KIND_READ;
            result_next.hit         = 1'b1;
            result_next.out_address = cur.address;
            result_next.out_data    = word_rdata;
          end else begin
            result_next.kind        = KIND_FILLREQ;
            result_next.out_address = {cur.address[ADDR_BITS-1:OFF_BITS],
                                       {OFF_BITS{1'b0}}};
            fill_pending_next       = 1'b1;
            fill_count_next         = '0;
          end
          state_next = S_IDLE;
        end else if (!hit) begin
          // write miss goes upstream alone
          strobe_next             = 1'b1;
          result_next.kind        = KIND_UPWRITE;
          result_next.out_address = cur.address;
          result_next.out_data    = cur.data;
          state_next              = S_IDLE;
        end else begin
          word_we        = 1'b1;
          burst_cnt_next = '0;
          state_next     = S_WBURST;
        end
      end
      S_WBURST: begin
        // read word n while word n-1 goes out
        if (!burst_cnt[OFF_BITS]) begin
          word_en   = 1'b1;
          word_addr = {cur_line, burst_cnt[OFF_BITS-1:0]};
        end
        if (burst_cnt != '0) begin
          strobe_next             = 1'b1;
          result_next.kind        = KIND_UPWRITE;
          result_next.hit         = 1'b1;
          result_next.out_address = {cur.address[ADDR_BITS-1:OFF_BITS], out_idx};
          result_next.out_data    = word_rdata;
          result_next.last        = burst_cnt[OFF_BITS];
        end
        burst_cnt_next = burst_cnt + 1'b1;
        if (burst_cnt[OFF_BITS]) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill_pending <= 1'b0;
      fill_count   <= '0;
      strobe       <= 1'b0;
    end else begin
      state        <= state_next;
      fill_pending <= fill_pending_next;
      fill_count   <= fill_count_next;
      strobe       <= strobe_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    result    <= result_next;
    fill_word <= fill_word_next;
    burst_cnt <= burst_cnt_next;
    if (accept) begin
      cur <= request;
    end
    if (state == S_LOOKUP && cur.command == CMD_READ && !hit) begin
      pending_address <= cur.address;
    end
  end

  `ASSERT_NEXT(a_fill_without_miss_rejected,
    accept && request.command == CMD_FILL && !fill_pending,
    strobe && result.kind == KIND_REJECT && result.last)
  `ASSERT_IMPL(a_no_burst_while_filling, state == S_WBURST, !fill_pending)
  `ASSERT_IMPL(a_burst_word_keeps_busy,
    strobe && result.kind == KIND_UPWRITE && result.hit && !result.last, busy)
  `ASSERT_NEXT(a_lookup_lasts_one_cycle, state == S_LOOKUP,
    strobe || state == S_WBURST)

endmodule

/* hdl/dmc_ram.sv */
module dmc_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (en) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* hdl/dmc_tag_dir.sv */
module dmc_tag_dir
  import dmc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  tag_req_t req,
  output logic     hit
);

  logic [NUM_LINES-1:0] valid;
  logic                 valid_q;
  logic [TAG_BITS-1:0]  tag_q;
  logic [TAG_BITS-1:0]  tag_rdata;

  // tag memory
  dmc_ram #(
    .DEPTH(NUM_LINES),
    .WIDTH(TAG_BITS)
  ) u_tag_ram (
    .clk  (clk),
    .en   (req.lookup),
    .we   (req.install),
    .addr (req.index),
    .wdata(req.tag),
    .rdata(tag_rdata)
  );

  // per-line valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.clear_all) begin
      valid <= '0;
    end else if (req.install) begin
      valid[req.index] <= 1'b1;
    end
  end

  // lookup side data, aligned with the tag read
  always_ff @(posedge clk) begin
    if (req.lookup) begin
      valid_q <= valid[req.index];
      tag_q   <= req.tag;
    end
  end

  assign hit = valid_q && (tag_rdata == tag_q);

endmodule
